@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

  localparam int WordW = 32;
  localparam int BlockBytes = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic [7:0] byte_val;
    logic clr_len;
    logic add_len;
    logic start_rounds;
    logic do_round;
    logic do_add;
    logic reinit;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic block_full;
    logic [5:0] round;
    logic [63:0] bits;
  } sts_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hw/rtl/sha256_message_hasher.sv @@
// SHA-256 hasher fed one message byte per word. A word without a byte and
// without last leaves the controller idle; a byte word passes through the
// schedule check before the next word is taken, and each full 64-byte
// block adds the 64 serial rounds of the single round unit and the final
// hash add. A last word pads the message one byte a cycle, pausing while a
// full block is hashed, runs the final one or two blocks, then presents
// the eight digest words H0 first and restarts from the initial hash. No
// word is taken while a block or the digest is in flight.
module sha256_message_hasher import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  cmd_t cmd;
  sts_t sts;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_has_byte,
    .in_is_last, .out_valid, .out_ready, .out_word_index, .out_last_word,
    .cmd, .sts
  );

  sha256_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .rd_idx(out_word_index), .rd_word(out_digest_word)
  );

endmodule

@@ hw/rtl/sha256_dp.sv @@
module sha256_dp import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  fill_r;
  logic        full_r;
  logic [5:0]  rnd_r;
  logic [63:0] bits_r;

  logic [31:0] s0, s1, wnew, wcur, t1, t2, b0, b1, ch, mj;

  // window w_r[0] is the current schedule word
  always_comb begin
    wcur = w_r[0];
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    b1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + b1 + ch + RK[rnd_r] + wcur;
    b0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = b0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      full_r <= 1'b0;
      bits_r <= '0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else begin
      if (cmd.add_len) bits_r <= bits_r + 64'd8;
      if (cmd.clr_len) bits_r <= '0;
      if (cmd.load_byte) begin
        w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], cmd.byte_val};
        fill_r <= fill_r + 6'd1;
        full_r <= (fill_r == 6'd63);
      end
      if (cmd.start_rounds) begin
        full_r <= 1'b0;
        rnd_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (cmd.do_round) begin
        rnd_r <= rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (cmd.do_add) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
        fill_r <= '0;
      end
    end
  end

  assign sts.fill = fill_r;
  assign sts.block_full = full_r;
  assign sts.round = rnd_r;
  assign sts.bits = bits_r;
  assign rd_word = h_r[rd_idx];

endmodule

@@ hw/rtl/sha256_ctrl.sv @@
module sha256_ctrl import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output cmd_t        cmd,
  input  sts_t        sts
);

  state_t      st_r, st_nxt;
  logic        last_r, last_nxt;
  logic        pad_r, pad_nxt;
  logic        ovf_r, ovf_nxt;
  logic        done_r, done_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        acc;

  assign acc = in_valid && in_ready;

  // padding byte selection
  logic [7:0] pad_byte;
  always_comb begin
    if (!pad_r) pad_byte = 8'h80;
    else if (ovf_r || sts.fill < 6'd56) pad_byte = 8'h00;
    else pad_byte = len_r[8'd63 - {2'b00, sts.fill[2:0], 3'b000} -: 8];
  end

  always_comb begin
    st_nxt = st_r;
    last_nxt = last_r;
    pad_nxt = pad_r;
    ovf_nxt = ovf_r;
    done_nxt = done_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          last_nxt = in_is_last;
          len_nxt = sts.bits + (in_has_byte ? 64'd8 : 64'd0);
          pad_nxt = 1'b0;
          ovf_nxt = 1'b0;
          done_nxt = 1'b0;
          if (in_has_byte) st_nxt = ST_SCHED;
          else if (in_is_last) st_nxt = ST_PAD;
        end
      end
      ST_SCHED: begin
        if (sts.block_full) st_nxt = ST_ROUND;
        else if (last_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_ROUND: begin
        if (sts.round == 6'd63) st_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (!last_r) st_nxt = ST_IDLE;
        else if (done_r) st_nxt = ST_EMIT;
        else st_nxt = ST_PAD;
      end
      ST_PAD: begin
        pad_nxt = 1'b1;
        // 0x80 too late for the length, rest of this block is zeros
        if (!pad_r && sts.fill >= 6'd56) ovf_nxt = 1'b1;
        if (sts.fill == 6'd63) begin
          st_nxt = ST_SCHED;
          ovf_nxt = 1'b0;
          if (pad_r && !ovf_r) done_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_byte = acc && in_has_byte;
        cmd.byte_val = in_data_byte;
        cmd.add_len = acc && in_has_byte;
      end
      ST_SCHED: cmd.start_rounds = sts.block_full;
      ST_ROUND: cmd.do_round = 1'b1;
      ST_ADD: cmd.do_add = 1'b1;
      ST_PAD: begin
        cmd.load_byte = 1'b1;
        cmd.byte_val = pad_byte;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && idx_r == 3'd7) begin
          cmd.reinit = 1'b1;
          cmd.clr_len = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      last_r <= 1'b0;
      pad_r <= 1'b0;
      ovf_r <= 1'b0;
      done_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      last_r <= last_nxt;
      pad_r <= pad_nxt;
      ovf_r <= ovf_nxt;
      done_r <= done_nxt;
      idx_r <= idx_nxt;
    end
    len_r <= len_nxt;
  end

  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd7);

endmodule
